// ===== rtl/hkm_pkg.sv =====
// shared constants and helpers for the hunt-and-kill maze carver
// no dependencies; imported by the top level and the testbench
package hkm_pkg;

    localparam int MAX_SIDE = 32;
    localparam int CW       = $clog2(MAX_SIDE);
    localparam int ROW_W    = 3 * MAX_SIDE;
    localparam int SIDE_W   = 6;
    localparam int TOTAL_W  = 11;

    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_CARVE = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    localparam logic [1:0] DIR_EAST  = 2'd0;
    localparam logic [1:0] DIR_SOUTH = 2'd1;
    localparam logic [1:0] DIR_WEST  = 2'd2;
    localparam logic [1:0] DIR_NORTH = 2'd3;

    function automatic logic [1:0] mod3_u8(input logic [7:0] v);
        logic [3:0] s;
        s = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]);
        if (s >= 4'd6) s = s - 4'd6;
        if (s >= 4'd3) s = s - 4'd3;
        if (s >= 4'd3) s = s - 4'd3;
        return s[1:0];
    endfunction

    function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
        if (v == '0) return SIDE_W'(1);
        if (v > SIDE_W'(MAX_SIDE)) return SIDE_W'(MAX_SIDE);
        return v;
    endfunction

endpackage

// ===== rtl/hkm_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module hkm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/hunt_and_kill_maze_carver_unit.sv =====
// hunt-and-kill maze carver, top level
// per transaction, accept to next accept: read S_RD0-S_RD3, S_DECIDE, S_OUT; walk step
// adds write-back S_WB0-S_WB2; hunt step scans rows in S_HRD/S_HCHK, then write-back, or
// S_OUT when nothing is found; idle carve goes to S_OUT; start runs the 32-row clearing
// pass; a result waiting on m_tready holds the next in S_OUT; reset: synchronous active-low,
// runs the clearing pass before the first transaction is taken, maze size returns to 8 x 8
module hunt_and_kill_maze_carver_unit
    import hkm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // random_word, query_x, query_y, zero fill
    input  logic [1:0]  s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // cell_x, cell_y, side, carved, finished, open_walls, zero fill
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [5:0]  cfg_data
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CLEAR  = 4'd1;
    localparam logic [3:0] S_RD0    = 4'd2;
    localparam logic [3:0] S_RD1    = 4'd3;
    localparam logic [3:0] S_RD2    = 4'd4;
    localparam logic [3:0] S_RD3    = 4'd5;
    localparam logic [3:0] S_DECIDE = 4'd6;
    localparam logic [3:0] S_HRD    = 4'd7;
    localparam logic [3:0] S_HCHK   = 4'd8;
    localparam logic [3:0] S_WB0    = 4'd9;
    localparam logic [3:0] S_WB1    = 4'd10;
    localparam logic [3:0] S_WB2    = 4'd11;
    localparam logic [3:0] S_OUT    = 4'd12;

    localparam logic [CW-1:0] LAST_ROW = CW'(MAX_SIDE - 1);

    logic [3:0]          state_reg, state_next;
    logic [SIDE_W-1:0]   width_reg, height_reg;
    logic [CW-1:0]       walk_x_reg, walk_x_next, walk_y_reg, walk_y_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                boot_reg, boot_next;
    logic [1:0]          mode_reg, mode_next;
    logic [7:0]          rnd_reg, rnd_next;
    logic [CW-1:0]       qx_reg, qx_next;
    logic [CW-1:0]       base_reg, base_next;
    logic                wr_n_reg, wr_n_next, wr_s_reg, wr_s_next;
    logic [MAX_SIDE-1:0] cv_reg, cv_next, ce_reg, ce_next, cs_reg, cs_next;
    logic [MAX_SIDE-1:0] nv_reg, nv_next, ne_reg, ne_next, ns_reg, ns_next;
    logic [MAX_SIDE-1:0] sv_reg, sv_next, se_reg, se_next, ss_reg, ss_next;
    logic [CW-1:0]       rx_reg, rx_next, ry_reg, ry_next;
    logic [1:0]          rside_reg, rside_next;
    logic                rcarved_reg, rcarved_next;
    logic [3:0]          rwalls_reg, rwalls_next;
    logic                m_valid_reg, m_valid_next;
    logic [17:0]         m_data_reg, m_data_next;

    logic                ram_we;
    logic [CW-1:0]       ram_waddr, ram_raddr;
    logic [ROW_W-1:0]    ram_wdata, ram_rdata;
    logic [MAX_SIDE-1:0] rd_v, rd_e, rd_s;

    logic [SIDE_W-1:0]   w, h;
    logic [11:0]         wh;
    logic                finished;
    logic [CW-1:0]       xp1, xm1;
    logic [3:0]          cand;
    logic [2:0]          ncand;
    logic [1:0]          pick, seen, dir;
    logic                got;
    logic [MAX_SIDE-1:0] col_mask, unvis;
    logic                found;
    logic [CW-1:0]       hx;
    logic                h_west, h_north;
    logic [1:0]          h_side;

    assign w        = clamp_side(width_reg);
    assign h        = clamp_side(height_reg);
    assign wh       = 12'(w) * 12'(h);
    assign finished = 12'(total_reg) >= wh;
    assign rd_v     = ram_rdata[MAX_SIDE-1:0];
    assign rd_e     = ram_rdata[2*MAX_SIDE-1:MAX_SIDE];
    assign rd_s     = ram_rdata[3*MAX_SIDE-1:2*MAX_SIDE];
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_data_reg};

    hkm_ram #(.WIDTH(ROW_W), .DEPTH(MAX_SIDE)) u_rows (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // walk candidates
    always_comb begin
        xp1 = walk_x_reg + CW'(1);
        xm1 = walk_x_reg - CW'(1);
        cand[0] = ({1'b0, walk_x_reg} + SIDE_W'(1) < w) && ({1'b0, walk_y_reg} < h)
                  && !cv_reg[xp1];
        cand[1] = ({1'b0, walk_x_reg} < w) && ({1'b0, walk_y_reg} + SIDE_W'(1) < h)
                  && !sv_reg[walk_x_reg];
        cand[2] = (walk_x_reg != '0) && ({1'b0, xm1} < w) && ({1'b0, walk_y_reg} < h)
                  && !cv_reg[xm1];
        cand[3] = (walk_y_reg != '0) && ({1'b0, walk_x_reg} < w)
                  && ({1'b0, walk_y_reg - CW'(1)} < h) && !nv_reg[walk_x_reg];
        ncand = 3'($countones(cand));
        case (ncand)
            3'd2:    pick = {1'b0, rnd_reg[0]};
            3'd3:    pick = mod3_u8(rnd_reg);
            3'd4:    pick = rnd_reg[1:0];
            default: pick = 2'd0;
        endcase
        dir  = DIR_EAST;
        seen = 2'd0;
        got  = 1'b0;
        for (int i = 0; i < 4; i++) begin
            if (cand[i] && !got) begin
                if (seen == pick) begin
                    dir = 2'(i);
                    got = 1'b1;
                end
                seen = seen + 2'd1;
            end
        end
    end

    // hunt row search
    always_comb begin
        col_mask = (w >= SIDE_W'(MAX_SIDE)) ? '1 : ((MAX_SIDE'(1) << w) - MAX_SIDE'(1));
        unvis    = ~rd_v & col_mask;
        found    = |unvis;
        hx       = '0;
        for (int i = MAX_SIDE - 1; i >= 0; i--) begin
            if (unvis[i]) hx = CW'(i);
        end
        h_west  = (hx != '0);
        h_north = (cnt_reg != '0);
        if (h_west && h_north) h_side = rnd_reg[0] ? DIR_NORTH : DIR_WEST;
        else if (h_west)       h_side = DIR_WEST;
        else                   h_side = DIR_NORTH;
    end

    always_comb begin
        state_next   = state_reg;
        walk_x_next  = walk_x_reg;
        walk_y_next  = walk_y_reg;
        total_next   = total_reg;
        cnt_next     = cnt_reg;
        boot_next    = boot_reg;
        mode_next    = mode_reg;
        rnd_next     = rnd_reg;
        qx_next      = qx_reg;
        base_next    = base_reg;
        wr_n_next    = wr_n_reg;
        wr_s_next    = wr_s_reg;
        cv_next = cv_reg; ce_next = ce_reg; cs_next = cs_reg;
        nv_next = nv_reg; ne_next = ne_reg; ns_next = ns_reg;
        sv_next = sv_reg; se_next = se_reg; ss_next = ss_reg;
        rx_next      = rx_reg;
        ry_next      = ry_reg;
        rside_next   = rside_reg;
        rcarved_next = rcarved_reg;
        rwalls_next  = rwalls_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        ram_we       = 1'b0;
        ram_waddr    = base_reg;
        ram_wdata    = {cs_reg, ce_reg, cv_reg};
        ram_raddr    = base_reg;

        if (m_valid_reg && m_tready) m_valid_next = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    mode_next    = s_tuser;
                    rnd_next     = s_tdata[7:0];
                    qx_next      = s_tdata[12:8];
                    rx_next      = walk_x_reg;
                    ry_next      = walk_y_reg;
                    rside_next   = DIR_EAST;
                    rcarved_next = 1'b0;
                    rwalls_next  = 4'd0;
                    if (s_tuser == MODE_START) begin
                        cnt_next    = '0;
                        walk_x_next = '0;
                        walk_y_next = '0;
                        total_next  = TOTAL_W'(1);
                        rx_next     = '0;
                        ry_next     = '0;
                        state_next  = S_CLEAR;
                    end else if (s_tuser == MODE_READ) begin
                        base_next  = s_tdata[17:13];
                        rx_next    = s_tdata[12:8];
                        ry_next    = s_tdata[17:13];
                        state_next = S_RD0;
                    end else if (s_tuser == MODE_CARVE && !finished) begin
                        base_next  = walk_y_reg;
                        state_next = S_RD0;
                    end else begin
                        state_next = S_OUT;
                    end
                end
            end
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg;
                ram_wdata = (cnt_reg == '0) ? ROW_W'(1) : '0;
                cnt_next  = cnt_reg + CW'(1);
                if (cnt_reg == LAST_ROW) begin
                    boot_next  = 1'b0;
                    state_next = boot_reg ? S_IDLE : S_OUT;
                end
            end
            S_RD0: begin
                state_next = S_RD1;
            end
            S_RD1: begin
                ram_raddr  = base_reg - CW'(1);
                cv_next = rd_v; ce_next = rd_e; cs_next = rd_s;
                state_next = S_RD2;
            end
            S_RD2: begin
                ram_raddr = base_reg + CW'(1);
                if (base_reg != '0) begin
                    nv_next = rd_v; ne_next = rd_e; ns_next = rd_s;
                end else begin
                    nv_next = '0; ne_next = '0; ns_next = '0;
                end
                state_next = S_RD3;
            end
            S_RD3: begin
                if (base_reg != LAST_ROW) begin
                    sv_next = rd_v; se_next = rd_e; ss_next = rd_s;
                end else begin
                    sv_next = '0; se_next = '0; ss_next = '0;
                end
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                if (mode_reg == MODE_READ) begin
                    if ({1'b0, qx_reg} < w && {1'b0, base_reg} < h) begin
                        rwalls_next[0] = ce_reg[qx_reg];
                        rwalls_next[1] = cs_reg[qx_reg];
                        rwalls_next[2] = (qx_reg != '0) && ce_reg[qx_reg - CW'(1)];
                        rwalls_next[3] = (base_reg != '0) && ns_reg[qx_reg];
                    end
                    state_next = S_OUT;
                end else if (ncand != '0) begin
                    case (dir)
                        DIR_EAST: begin
                            ce_next[walk_x_reg] = 1'b1;
                            cv_next[xp1]        = 1'b1;
                            walk_x_next         = xp1;
                        end
                        DIR_SOUTH: begin
                            cs_next[walk_x_reg] = 1'b1;
                            sv_next[walk_x_reg] = 1'b1;
                            walk_y_next         = walk_y_reg + CW'(1);
                        end
                        DIR_WEST: begin
                            ce_next[xm1] = 1'b1;
                            cv_next[xm1] = 1'b1;
                            walk_x_next  = xm1;
                        end
                        default: begin
                            ns_next[walk_x_reg] = 1'b1;
                            nv_next[walk_x_reg] = 1'b1;
                            walk_y_next         = walk_y_reg - CW'(1);
                        end
                    endcase
                    if (total_reg != '1) total_next = total_reg + TOTAL_W'(1);
                    rside_next   = dir;
                    rcarved_next = 1'b1;
                    wr_n_next    = (base_reg != '0);
                    wr_s_next    = (base_reg != LAST_ROW);
                    state_next   = S_WB0;
                end else begin
                    cnt_next   = '0;
                    nv_next    = '0; ne_next = '0; ns_next = '0;
                    state_next = S_HRD;
                end
            end
            S_HRD: begin
                ram_raddr  = cnt_reg;
                state_next = S_HCHK;
            end
            S_HCHK: begin
                if (found) begin
                    cv_next = rd_v; ce_next = rd_e; cs_next = rd_s;
                    cv_next[hx] = 1'b1;
                    if (h_west || h_north) begin
                        rcarved_next = 1'b1;
                        rside_next   = h_side;
                        if (h_side == DIR_WEST) ce_next[hx - CW'(1)] = 1'b1;
                        else                    ns_next[hx] = 1'b1;
                    end
                    if (total_reg != '1) total_next = total_reg + TOTAL_W'(1);
                    walk_x_next = hx;
                    walk_y_next = cnt_reg;
                    rx_next     = hx;
                    ry_next     = cnt_reg;
                    base_next   = cnt_reg;
                    wr_n_next   = (cnt_reg != '0);
                    wr_s_next   = 1'b0;
                    state_next  = S_WB0;
                end else begin
                    nv_next = rd_v; ne_next = rd_e; ns_next = rd_s;
                    cnt_next = cnt_reg + CW'(1);
                    if ({1'b0, cnt_reg} + SIDE_W'(1) >= h) state_next = S_OUT;
                    else                                   state_next = S_HRD;
                end
            end
            S_WB0: begin
                ram_we     = 1'b1;
                state_next = S_WB1;
            end
            S_WB1: begin
                ram_we     = wr_n_reg;
                ram_waddr  = base_reg - CW'(1);
                ram_wdata  = {ns_reg, ne_reg, nv_reg};
                state_next = S_WB2;
            end
            S_WB2: begin
                ram_we     = wr_s_reg;
                ram_waddr  = base_reg + CW'(1);
                ram_wdata  = {ss_reg, se_reg, sv_reg};
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {rwalls_reg, finished, rcarved_reg, rside_reg,
                                    ry_reg, rx_reg};
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            boot_reg    <= 1'b1;
            cnt_reg     <= '0;
            width_reg   <= SIDE_W'(8);
            height_reg  <= SIDE_W'(8);
            walk_x_reg  <= '0;
            walk_y_reg  <= '0;
            total_reg   <= TOTAL_W'(1);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            boot_reg    <= boot_next;
            cnt_reg     <= cnt_next;
            walk_x_reg  <= walk_x_next;
            walk_y_reg  <= walk_y_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                if (cfg_index == 1'b0) width_reg  <= cfg_data;
                else                   height_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg    <= mode_next;
        rnd_reg     <= rnd_next;
        qx_reg      <= qx_next;
        base_reg    <= base_next;
        wr_n_reg    <= wr_n_next;
        wr_s_reg    <= wr_s_next;
        cv_reg <= cv_next; ce_reg <= ce_next; cs_reg <= cs_next;
        nv_reg <= nv_next; ne_reg <= ne_next; ns_reg <= ns_next;
        sv_reg <= sv_next; se_reg <= se_next; ss_reg <= ss_next;
        rx_reg      <= rx_next;
        ry_reg      <= ry_next;
        rside_reg   <= rside_next;
        rcarved_reg <= rcarved_next;
        rwalls_reg  <= rwalls_next;
        m_data_reg  <= m_data_next;
    end

    a_total_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg != '0)
        else $error("visited count dropped to zero");

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg != S_IDLE))
        else $error("transaction accepted without leaving idle");

    a_write_states: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == S_CLEAR || state_reg == S_WB0 ||
                    state_reg == S_WB1 || state_reg == S_WB2))
        else $error("row write outside clear or write-back");

    a_result_once: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && state_next == S_IDLE) |=> m_tvalid)
        else $error("result not presented");

endmodule

// ===== dv/hunt_and_kill_maze_carver_unit_test.sv =====
// testbench for the hunt-and-kill maze carver: drives start, carve, read and unused-mode
// transactions and checks every result against an in-bench maze predictor
// depends on rtl/hkm_pkg.sv and rtl/hunt_and_kill_maze_carver_unit.sv
module hunt_and_kill_maze_carver_unit_test
    import hkm_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] rnd;
        logic [4:0] qx;
        logic [4:0] qy;
    } step_t;

    typedef struct packed {
        logic [4:0] cx;
        logic [4:0] cy;
        logic [1:0] side;
        logic       carved;
        logic       finished;
        logic [3:0] walls;
    } cell_report_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [23:0] m_tdata;
    logic        cfg_we = 0;
    logic        cfg_index = 0;
    logic [5:0]  cfg_data = '0;

    hunt_and_kill_maze_carver_unit DUT (.*);

    always begin
        #10 aclk = 1;
        #10 aclk = 0;
    end

    // predictor state
    logic [5:0]  cfg_w, cfg_h;
    logic        seen_map  [MAX_SIDE][MAX_SIDE];
    logic        east_map  [MAX_SIDE][MAX_SIDE];
    logic        south_map [MAX_SIDE][MAX_SIDE];
    int unsigned pos_x, pos_y, seen_total;

    step_t        pending_steps[$];
    cell_report_t expected_reports[$];
    int  failures = 0;
    int  idle_cycles = 0;
    bit  send_gaps = 1, recv_gaps = 1, hold_recv = 0;
    int  send_gap = 0, recv_gap = 0, hold_count = 0;

    function automatic int unsigned side_used(input logic [5:0] v);
        if (v == 0) return 1;
        if (v > MAX_SIDE) return MAX_SIDE;
        return 32'(v);
    endfunction

    task automatic clear_maze();
        for (int y = 0; y < MAX_SIDE; y++)
            for (int x = 0; x < MAX_SIDE; x++) begin
                seen_map[y][x] = 0;
                east_map[y][x] = 0;
                south_map[y][x] = 0;
            end
        seen_map[0][0] = 1;
        pos_x = 0;
        pos_y = 0;
        seen_total = 1;
    endtask

    task automatic open_side(input int unsigned x, input int unsigned y, input logic [1:0] d);
        if (d == DIR_EAST) east_map[y][x] = 1;
        else if (d == DIR_SOUTH) south_map[y][x] = 1;
        else if (d == DIR_WEST) east_map[y][x-1] = 1;
        else south_map[y-1][x] = 1;
    endtask

    task automatic enter_cell(input int unsigned x, input int unsigned y);
        seen_map[y][x] = 1;
        if (seen_total < 2047) seen_total++;
        pos_x = x;
        pos_y = y;
    endtask

    task automatic predict_step(input step_t st);
        int unsigned w, h, x, y, n, hx, hy;
        logic [1:0] d;
        logic [1:0] opts[4];
        bit found;
        cell_report_t r;
        w = side_used(cfg_w);
        h = side_used(cfg_h);
        x = pos_x;
        y = pos_y;
        r = '0;
        r.cx = 5'(pos_x);
        r.cy = 5'(pos_y);
        n = 0;
        found = 0;
        hx = 0;
        hy = 0;
        if (st.mode == MODE_START) begin
            clear_maze();
            r.cx = 0;
            r.cy = 0;
        end else if (st.mode == MODE_READ) begin
            r.cx = st.qx;
            r.cy = st.qy;
            if (st.qx < w && st.qy < h) begin
                r.walls[0] = east_map[st.qy][st.qx];
                r.walls[1] = south_map[st.qy][st.qx];
                r.walls[2] = st.qx > 0 && east_map[st.qy][st.qx-1];
                r.walls[3] = st.qy > 0 && south_map[st.qy-1][st.qx];
            end
        end else if (st.mode == MODE_CARVE && seen_total < w * h) begin
            if (x + 1 < w && y < h && !seen_map[y][x+1]) opts[n++] = DIR_EAST;
            if (x < w && y + 1 < h && !seen_map[y+1][x]) opts[n++] = DIR_SOUTH;
            if (x >= 1 && x - 1 < w && y < h && !seen_map[y][x-1]) opts[n++] = DIR_WEST;
            if (y >= 1 && x < w && y - 1 < h && !seen_map[y-1][x]) opts[n++] = DIR_NORTH;
            if (n > 0) begin
                d = opts[st.rnd % n];
                open_side(x, y, d);
                if (d == DIR_EAST) enter_cell(x + 1, y);
                else if (d == DIR_SOUTH) enter_cell(x, y + 1);
                else if (d == DIR_WEST) enter_cell(x - 1, y);
                else enter_cell(x, y - 1);
                r.side = d;
                r.carved = 1;
            end else begin
                for (int sy = 0; sy < h && !found; sy++)
                    for (int sx = 0; sx < w && !found; sx++)
                        if (!seen_map[sy][sx]) begin
                            hx = sx;
                            hy = sy;
                            found = 1;
                        end
                if (found) begin
                    enter_cell(hx, hy);
                    r.cx = 5'(hx);
                    r.cy = 5'(hy);
                    n = 0;
                    if (hx > 0 && seen_map[hy][hx-1]) opts[n++] = DIR_WEST;
                    if (hy > 0 && seen_map[hy-1][hx]) opts[n++] = DIR_NORTH;
                    if (n > 0) begin
                        r.side = opts[st.rnd % n];
                        open_side(hx, hy, r.side);
                        r.carved = 1;
                    end
                end
            end
        end
        r.finished = seen_total >= w * h;
        expected_reports = {expected_reports, r};
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) predict_step(pending_steps.pop_front());
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 0;
            end else if (send_gaps && $urandom_range(0, 9) == 0) begin
                send_gap = $urandom_range(0, 17);
                s_tvalid <= 0;
            end else if (pending_steps.size() > 0) begin
                s_tvalid <= 1;
                s_tuser <= pending_steps[0].mode;
                s_tdata <= {6'd0, pending_steps[0].qy, pending_steps[0].qx,
                            pending_steps[0].rnd};
            end else begin
                s_tvalid <= 0;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        cell_report_t got, want;
        if (aresetn) begin
            if (s_tvalid && s_tready || m_tvalid && m_tready) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles > 20000) begin
                $display("FAILED: results differ");
                $finish;
            end
            if (m_tvalid && m_tready) begin
                got = '{cx: m_tdata[4:0], cy: m_tdata[9:5], side: m_tdata[11:10],
                        carved: m_tdata[12], finished: m_tdata[13],
                        walls: m_tdata[17:14]};
                if (expected_reports.size() == 0) begin
                    $display("%0t unexpected result %h", $time, got);
                    failures++;
                end else begin
                    want = expected_reports.pop_front();
                    if (got !== want) begin
                        $display("%0t mismatch expected %p actual %p", $time, want, got);
                        failures++;
                    end
                end
            end
            if (hold_recv) begin
                m_tready <= 0;
                if (++hold_count >= 400) begin
                    hold_recv = 0;
                    hold_count = 0;
                end
            end else if (recv_gap > 0) begin
                recv_gap--;
                m_tready <= 0;
            end else if (recv_gaps && $urandom_range(0, 9) == 0) begin
                recv_gap = $urandom_range(0, 17);
                m_tready <= 0;
            end else begin
                m_tready <= 1;
            end
        end
    end

    task automatic write_reg(input logic idx, input logic [5:0] v);
        @(posedge aclk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge aclk);
        cfg_we <= 0;
        if (idx == 0) cfg_w = v;
        else cfg_h = v;
    endtask

    task automatic drain();
        while (pending_steps.size() > 0 || s_tvalid || expected_reports.size() > 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic add_step(input step_t st);
        pending_steps = {pending_steps, st};
    endtask

    function automatic step_t make_step(input logic [1:0] m);
        step_t st;
        st.mode = m;
        st.rnd = 8'($urandom_range(0, 255));
        st.qx = 5'($urandom_range(0, 31));
        st.qy = 5'($urandom_range(0, 31));
        return st;
    endfunction

    // starts a maze, then mostly carve steps with reads, restarts and unused-mode steps between
    task automatic queue_maze(input int steps);
        add_step(make_step(MODE_START));
        for (int i = 0; i < steps; i++) begin
            int k;
            k = $urandom_range(0, 19);
            if (k == 0) add_step(make_step(MODE_START));
            else if (k == 1) add_step(make_step(2'd3));
            else if (k < 6) add_step(make_step(MODE_READ));
            else add_step(make_step(MODE_CARVE));
        end
    endtask

    initial begin
        step_t st;
        cfg_w = 8;
        cfg_h = 8;
        clear_maze();
        repeat (10) @(posedge aclk);
        aresetn <= 1;
        repeat (40) @(posedge aclk);

        // directed: small maze walked to completion, reads at the extremes
        write_reg(1'b0, 6'd3);
        write_reg(1'b1, 6'd2);
        add_step(make_step(MODE_START));
        for (int i = 0; i < 7; i++) begin
            st = make_step(MODE_CARVE);
            st.rnd = (i % 2) ? 8'hff : 8'h00;
            add_step(st);
        end
        st = make_step(2'd3);
        add_step(st);
        for (int i = 0; i < 4; i++) begin
            st = make_step(MODE_READ);
            st.qx = (i % 2) ? 5'd31 : 5'd0;
            st.qy = (i / 2) ? 5'd1 : 5'd0;
            add_step(st);
        end
        st = make_step(MODE_READ);
        st.qx = 5'd2;
        st.qy = 5'd1;
        add_step(st);
        drain();

        // clamped sizes and a shrink in mid maze
        write_reg(1'b0, 6'd0);
        write_reg(1'b1, 6'd63);
        queue_maze(40);
        drain();
        write_reg(1'b0, 6'd32);
        write_reg(1'b1, 6'd32);
        queue_maze(120);
        hold_recv = 1;
        drain();
        write_reg(1'b0, 6'd5);
        write_reg(1'b1, 6'd4);
        for (int i = 0; i < 30; i++) add_step(make_step(MODE_CARVE));
        drain();

        // random sizes, mostly small
        for (int p = 0; p < 14; p++) begin
            write_reg(1'b0, ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
                                                       : 6'($urandom_range(1, 8)));
            write_reg(1'b1, ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
                                                       : 6'($urandom_range(1, 8)));
            if (p >= 12) begin
                send_gaps = 0;
                recv_gaps = 0;
            end
            queue_maze(80);
            drain();
        end

        if (failures == 0 && expected_reports.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule

// ===== files.f =====
rtl/hkm_pkg.sv
rtl/hkm_ram.sv
rtl/hunt_and_kill_maze_carver_unit.sv
dv/hunt_and_kill_maze_carver_unit_test.sv
